>>> design/temporal_median3_background_top_assert.svh
`ifndef TEMPORAL_MEDIAN3_BACKGROUND_TOP_ASSERT_SVH
`define TEMPORAL_MEDIAN3_BACKGROUND_TOP_ASSERT_SVH

// same-cycle implication
`define TM3B_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in temporal median background");

// next-cycle implication
`define TM3B_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in temporal median background");

`endif

>>> design/tm3b_pkg.sv
package tm3b_pkg;

    localparam int IDX_W = 16;
    localparam int BYTE_W = 8;
    localparam int RANGE_W = 25;
    localparam logic [RANGE_W-1:0] FRAME_BYTES = 25'd65536;
    localparam int STORE_DEPTH = 1 << IDX_W;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_HOLD   = 2'd1,
        PH_MEDIAN = 2'd2
    } tm3b_phase_t;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_READ = 1'b1
    } tm3b_action_t;

    typedef struct packed {
        logic              bg_we;
        logic              held_we;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } tm3b_wr_t;

    typedef struct packed {
        logic retire;
        logic last;
    } tm3b_frame_evt_t;

    function automatic logic [BYTE_W-1:0] median3(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] res;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
        begin
            res = lo;
        end
        else if (c >= hi)
        begin
            res = hi;
        end
        else
        begin
            res = c;
        end
        return res;
    endfunction

endpackage

>>> design/tm3b_store.sv
module tm3b_store
    import tm3b_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    input  tm3b_wr_t          wr,
    output logic [BYTE_W-1:0] bg_q,
    output logic [BYTE_W-1:0] held_q
);

    logic [BYTE_W-1:0] bg_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] held_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] bg_q_reg;
    logic [BYTE_W-1:0] held_q_reg;
    logic              addr_hit;

    assign addr_hit = (wr.addr == rd_addr);

    // write-first bypass on a same-cycle hit
    always_ff @(posedge clk)
    begin
        if (wr.bg_we)
        begin
            bg_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            bg_q_reg <= (wr.bg_we && addr_hit) ? wr.data : bg_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.held_we)
        begin
            held_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            held_q_reg <= (wr.held_we && addr_hit) ? wr.data : held_mem[rd_addr];
        end
    end

    assign bg_q = bg_q_reg;
    assign held_q = held_q_reg;

endmodule

>>> design/tm3b_phase.sv
module tm3b_phase
    import tm3b_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  tm3b_frame_evt_t evt,
    output tm3b_phase_t     phase,
    output logic            frame_seen
);

    tm3b_phase_t phase_reg;
    tm3b_phase_t phase_next;
    logic        frame_seen_reg;
    logic        frame_seen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            frame_seen_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            frame_seen_reg <= frame_seen_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        frame_seen_next = frame_seen_reg;
        if (evt.retire && evt.last)
        begin
            frame_seen_next = 1'b1;
            unique case (phase_reg)
                PH_HOLD:
                begin
                    phase_next = PH_MEDIAN;
                end
                default:
                begin
                    phase_next = PH_HOLD;
                end
            endcase
        end
    end

    assign phase = phase_reg;
    assign frame_seen = frame_seen_reg;

endmodule

>>> design/temporal_median3_background_top.sv
// Per-byte background model updated by a running median of three frames. Requests
// are taken one per clock with no bubbles unless a stalled output holds the request
// stage: a request's store entries are read in the cycle it is accepted; when the
// request stage advances it forms the new background byte, writes it back and loads
// the output register. The two 64K x 8 stores register their read data and bypass a
// write to the entry being read in the same cycle, so repeated indexes need no interlock.
// Stores are not cleared after reset; an entry must be written before it is read.
module temporal_median3_background_top
    import tm3b_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [IDX_W-1:0]  index,
    input  logic [BYTE_W-1:0] sample,
    input  logic              last_in_frame,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] value,
    output logic              ready_res
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_action_reg;
    logic [IDX_W-1:0]  s1_index_reg;
    logic [BYTE_W-1:0] s1_sample_reg;
    logic              s1_last_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_value_reg;
    logic              out_ready_reg;

    logic              in_accept;
    logic              s1_adv;
    logic              s1_push;
    logic              in_range;
    logic [BYTE_W-1:0] bg_rd;
    logic [BYTE_W-1:0] held_rd;
    logic [BYTE_W-1:0] new_bg;
    logic              bg_we;
    logic              held_we;
    tm3b_wr_t          wr;
    tm3b_frame_evt_t   evt;
    tm3b_phase_t       phase;
    logic              frame_seen;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign s1_push = (s1_action_reg == ACT_PUSH);
    assign in_range = ({{(RANGE_W-IDX_W){1'b0}}, s1_index_reg} < FRAME_BYTES);

    tm3b_store u_store (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (index),
        .wr      (wr),
        .bg_q    (bg_rd),
        .held_q  (held_rd)
    );

    assign evt.retire = s1_adv && s1_push;
    assign evt.last = s1_last_reg;

    tm3b_phase u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .phase      (phase),
        .frame_seen (frame_seen)
    );

    always_comb
    begin
        bg_we = 1'b0;
        held_we = 1'b0;
        new_bg = bg_rd;
        if (s1_push)
        begin
            unique case (phase)
                PH_HOLD:
                begin
                    held_we = 1'b1;
                    new_bg = bg_rd;
                end
                PH_MEDIAN:
                begin
                    bg_we = 1'b1;
                    new_bg = median3(bg_rd, held_rd, s1_sample_reg);
                end
                default:
                begin
                    bg_we = 1'b1;
                    new_bg = s1_sample_reg;
                end
            endcase
        end
    end

    assign wr.bg_we = bg_we && s1_adv && in_range;
    assign wr.held_we = held_we && s1_adv && in_range;
    assign wr.addr = s1_index_reg;
    assign wr.data = (phase == PH_HOLD) ? s1_sample_reg : new_bg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_index_reg <= index;
            s1_sample_reg <= sample;
            s1_last_reg <= last_in_frame;
        end
        if (s1_adv)
        begin
            out_value_reg <= in_range ? new_bg : '0;
            out_ready_reg <= frame_seen || (s1_push && s1_last_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign value = out_value_reg;
    assign ready_res = out_ready_reg;

endmodule

>>> design/tm3b_checker.sv
`include "temporal_median3_background_top_assert.svh"

module tm3b_checker
    import tm3b_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BYTE_W-1:0] value,
    input logic              ready_res
);

    logic seen_reg;

    // sticky: a result already reported a complete frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && ready_res)
        begin
            seen_reg <= 1'b1;
        end
    end

    `TM3B_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid)
    `TM3B_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `TM3B_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(value) && $stable(ready_res))
    `TM3B_ASSERT_NOW(a_stall_backpressure, in_stall, out_valid && out_stall)
    `TM3B_ASSERT_NOW(a_ready_sticky, out_valid && seen_reg, ready_res)

endmodule

bind temporal_median3_background_top tm3b_checker u_tm3b_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .ready_res (ready_res)
);

>>> tb/tb_temporal_median3_background_top.sv
`timescale 1ns / 1ps

module tb_temporal_median3_background_top;
    import tm3b_pkg::*;

    localparam int HOLD_OFF_CYCLES = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_ITEMS = 120;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              ready;
    } bg_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              action = ACT_PUSH;
    logic [IDX_W-1:0]  index = '0;
    logic [BYTE_W-1:0] sample = '0;
    logic              last_in_frame = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] value;
    logic              ready_res;

    // background model state
    logic [BYTE_W-1:0] bg_model [STORE_DEPTH];
    logic [BYTE_W-1:0] held_model [STORE_DEPTH];
    bit                bg_written [STORE_DEPTH];
    bit                held_written [STORE_DEPTH];
    logic [IDX_W-1:0]  bg_idx_q [$];
    logic [IDX_W-1:0]  held_idx_q [$];
    tm3b_phase_t       frame_phase = PH_FIRST;
    logic              frame_seen_m = 1'b0;
    bg_result_t        bg_expect_q [$];

    bit calm = 1'b0;
    bit hold_off_req = 1'b0;
    int hold_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;

    temporal_median3_background_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .index         (index),
        .sample        (sample),
        .last_in_frame (last_in_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value         (value),
        .ready_res     (ready_res)
    );

    always #5 clk = ~clk;

    function automatic logic [BYTE_W-1:0] mid_of_three(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic [BYTE_W-1:0] mn;
        logic [BYTE_W-1:0] mx;
        logic [BYTE_W-1:0] cap;
        mn = (b < a) ? b : a;
        mx = (b < a) ? a : b;
        cap = (c < mx) ? c : mx;
        return (cap > mn) ? cap : mn;
    endfunction

    function automatic bg_result_t step_background(
        input tm3b_action_t      act,
        input logic [IDX_W-1:0]  idx,
        input logic [BYTE_W-1:0] smp,
        input logic              lst
    );
        bg_result_t res;
        if (act == ACT_PUSH)
        begin
            case (frame_phase)
                PH_HOLD:
                begin
                    held_model[idx] = smp;
                    if (!held_written[idx])
                    begin
                        held_written[idx] = 1'b1;
                        held_idx_q.push_back(idx);
                    end
                end
                PH_MEDIAN:
                begin
                    bg_model[idx] = mid_of_three(bg_model[idx], held_model[idx], smp);
                end
                default:
                begin
                    bg_model[idx] = smp;
                    if (!bg_written[idx])
                    begin
                        bg_written[idx] = 1'b1;
                        bg_idx_q.push_back(idx);
                    end
                end
            endcase
            if (lst)
            begin
                frame_phase = (frame_phase == PH_HOLD) ? PH_MEDIAN : PH_HOLD;
                frame_seen_m = 1'b1;
            end
        end
        res.value = bg_model[idx];
        res.ready = frame_seen_m;
        return res;
    endfunction

    // only entries already written may be touched
    function automatic logic [IDX_W-1:0] pick_push_index();
        case (frame_phase)
            PH_FIRST:  return IDX_W'($urandom_range(0, STORE_DEPTH - 1));
            PH_HOLD:   return bg_idx_q[$urandom_range(0, bg_idx_q.size() - 1)];
            default:   return held_idx_q[$urandom_range(0, held_idx_q.size() - 1)];
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_req(
        input tm3b_action_t      act,
        input logic [IDX_W-1:0]  idx,
        input logic [BYTE_W-1:0] smp,
        input logic              lst
    );
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        index <= idx;
        sample <= smp;
        last_in_frame <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bg_expect_q.push_back(step_background(act, idx, smp, lst));
    endtask

    task automatic send_read();
        send_req(ACT_READ, bg_idx_q[$urandom_range(0, bg_idx_q.size() - 1)],
                 BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_first_frame();
        logic [IDX_W-1:0] pattern [9] = '{16'hFFFF, 16'h5555, 16'hAAAA, 16'h00FF,
                                          16'hFF00, 16'h0F0F, 16'hF0F0, 16'h8000,
                                          16'h0001};
        int k;
        send_req(ACT_PUSH, 16'h0000, 8'h00, 1'b0);
        // read before any frame completes, end mark must be ignored
        send_req(ACT_READ, 16'h0000, 8'hA5, 1'b1);
        send_req(ACT_PUSH, pattern[0], 8'hFF, 1'b0);
        for (k = 1; k < 9; k++)
            send_req(ACT_PUSH, pattern[k], pick_sample(), 1'b0);
        send_req(ACT_PUSH, pick_push_index(), pick_sample(), 1'b0);
        send_req(ACT_PUSH, 16'h0000, 8'h7F, 1'b0);
        send_req(ACT_PUSH, pick_push_index(), pick_sample(), 1'b1);
        send_req(ACT_READ, 16'hFFFF, 8'h00, 1'b0);
    endtask

    task automatic test_hold_median();
        send_req(ACT_PUSH, 16'h0000, 8'hFF, 1'b0);
        send_req(ACT_PUSH, 16'hFFFF, 8'h00, 1'b0);
        send_req(ACT_PUSH, 16'h5555, 8'h80, 1'b1);
        send_req(ACT_PUSH, 16'h0000, 8'h00, 1'b0);
        send_req(ACT_PUSH, 16'hFFFF, 8'hFF, 1'b0);
        send_req(ACT_PUSH, 16'h5555, 8'hC8, 1'b0);
        send_req(ACT_READ, 16'h5555, 8'hFF, 1'b0);
        // same index twice in one median frame
        send_req(ACT_PUSH, 16'h0000, 8'hC8, 1'b1);
        // hold frame of a single byte
        send_req(ACT_PUSH, 16'hFFFF, 8'h3C, 1'b1);
        send_req(ACT_READ, 16'hFFFF, 8'h00, 1'b1);
    endtask

    task automatic test_backpressure();
        int n;
        hold_off_req = 1'b1;
        for (n = 0; n < 30; n++)
            send_req(ACT_PUSH, pick_push_index(), pick_sample(), $urandom_range(0, 9) == 0);
    endtask

    task automatic test_random_frames();
        int sent;
        int flen;
        int k;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            flen = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
            for (k = 0; k < flen; k++)
            begin
                if (sent >= RANDOM_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                if ($urandom_range(0, 4) == 0)
                begin
                    send_read();
                    sent++;
                end
                send_req(ACT_PUSH, pick_push_index(), pick_sample(), k == flen - 1);
                sent++;
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch: %s", msg);
    endtask

    // receiver: random stall bursts plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        bg_result_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_valid && !out_stall)
            begin
                if (bg_expect_q.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result value=%0d ready=%0b",
                                            value, ready_res));
                end
                else
                begin
                    want = bg_expect_q.pop_front();
                    if (value !== want.value)
                        note_mismatch($sformatf("value expected %0d, got %0d",
                                                want.value, value));
                    if (ready_res !== want.ready)
                        note_mismatch($sformatf("ready_res expected %0b, got %0b",
                                                want.ready, ready_res));
                end
            end
        end
    end

    initial
    begin
        wait (rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_frame();
        test_hold_median();
        test_backpressure();
        test_random_frames();
        in_valid <= 1'b0;
        while (bg_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
